### hw/rtl/ptt_pkg.sv
// Package for the pending command timeout table.
// Holds the transfer payload types, the table entry layout and the action and status codes.
// Depends on nothing.
`default_nettype none

package ptt_pkg;

	// Field widths.
	localparam int ID_W = 31;
	localparam int CODE_W = 16;
	localparam int CITY_W = 16;
	localparam int LIFE_W = 8;
	localparam int COUNT_W = 6;

	// Action codes of an input item.
	localparam logic [1:0] ACT_ADD = 2'd0;
	localparam logic [1:0] ACT_RESPONSE = 2'd1;
	localparam logic [1:0] ACT_TICK = 2'd2;

	// Status codes of a result item.
	localparam logic [1:0] STS_OK = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_NOT_FOUND = 2'd2;

	// Id counter limits and reset values.
	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
	localparam logic [ID_W-1:0] ID_FIRST = ID_W'(1);
	localparam logic [ID_W-1:0] ID_RESET = ID_W'(1);
	localparam logic [LIFE_W-1:0] TIMEOUT_RESET = LIFE_W'(6);
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Input item.
	typedef struct packed {
		logic [1:0] action;
		logic signed [CODE_W-1:0] cmd_code;
		logic [CITY_W-1:0] city_tag;
		logic [ID_W-1:0] request_id;
	} req_t;

	// Result item.
	typedef struct packed {
		logic [ID_W-1:0] issued_id;
		logic [1:0] status;
		logic [COUNT_W-1:0] expired_count;
	} res_t;

	// One table entry as held in the entry memory.
	typedef struct packed {
		logic valid;
		logic [ID_W-1:0] id;
		logic [CODE_W-1:0] cmd;
		logic [CITY_W-1:0] city;
		logic [LIFE_W-1:0] lifetime;
	} entry_t;

endpackage

`default_nettype wire

### hw/rtl/ptt_entry_ram.sv
// Entry memory of the pending command timeout table.
// One write port and one read port with registered read data; uses ptt_pkg::entry_t.
`default_nettype none

module ptt_entry_ram #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire ptt_pkg::entry_t wr_data,
	input wire logic rd_en,
	input wire logic [AW-1:0] rd_addr,
	output ptt_pkg::entry_t rd_data
);

	ptt_pkg::entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/ptt_sweep.sv
// Sweep engine of the pending command timeout table.
// Reads every entry once per item, modifies it and writes it back; instantiates ptt_entry_ram.
// Uses ptt_pkg for types and codes.
`default_nettype none

module ptt_sweep #(
	parameter int TABLE_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire ptt_pkg::req_t req,
	input wire logic [ptt_pkg::LIFE_W-1:0] timeout_ticks,
	input wire logic res_free,
	output logic idle,
	output logic res_load,
	output ptt_pkg::res_t result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

	// Engine states.
	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_SWEEP = 2'd2;
	localparam logic [1:0] S_RESULT = 2'd3;

	logic [1:0] state_q;
	logic [AW-1:0] addr_q;
	logic issue_done_q;
	logic rd_v_s1;
	logic [AW-1:0] addr_s1;
	logic found_q;
	logic [ptt_pkg::ID_W-1:0] last_id_q;
	logic [ptt_pkg::ID_W-1:0] issued_q;
	logic [ptt_pkg::COUNT_W-1:0] count_q;
	ptt_pkg::req_t req_q;

	logic rd_en;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	ptt_pkg::entry_t wr_data;
	ptt_pkg::entry_t rd_data;
	logic hit;
	logic expire;
	logic [ptt_pkg::ID_W-1:0] next_id;

	ptt_entry_ram #(
		.DEPTH(TABLE_DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// The id counter wraps from its maximum back to one.
	assign next_id = (last_id_q == ptt_pkg::ID_MAX) ? ptt_pkg::ID_FIRST
		: last_id_q + ptt_pkg::ID_W'(1);

	assign rd_en = (state_q == S_SWEEP) && !issue_done_q;

	// Modify step on the entry that the memory returned this cycle.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = addr_s1;
		wr_data = rd_data;
		hit = 1'b0;
		expire = 1'b0;
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
			wr_addr = addr_q;
			wr_data = '0;
		end else if (state_q == S_SWEEP && rd_v_s1) begin
			case (req_q.action)
				ptt_pkg::ACT_ADD: begin
					if (!found_q && !rd_data.valid) begin
						hit = 1'b1;
						wr_en = 1'b1;
						wr_data.valid = 1'b1;
						wr_data.id = next_id;
						wr_data.cmd = req_q.cmd_code;
						wr_data.city = req_q.city_tag;
						wr_data.lifetime = timeout_ticks;
					end
				end
				ptt_pkg::ACT_RESPONSE: begin
					if (!found_q && rd_data.valid && rd_data.id == req_q.request_id) begin
						hit = 1'b1;
						wr_en = 1'b1;
						wr_data = '0;
					end
				end
				ptt_pkg::ACT_TICK: begin
					if (rd_data.valid) begin
						wr_en = 1'b1;
						if (rd_data.lifetime <= ptt_pkg::LIFE_W'(1)) begin
							expire = 1'b1;
							wr_data = '0;
						end else begin
							wr_data.lifetime = rd_data.lifetime - ptt_pkg::LIFE_W'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer: clearing pass after reset, then one sweep per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			addr_q <= '0;
			issue_done_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			last_id_q <= ptt_pkg::ID_RESET;
			issued_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q <= '0;
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						addr_q <= '0;
						issue_done_q <= 1'b0;
						rd_v_s1 <= 1'b0;
						found_q <= 1'b0;
						issued_q <= '0;
						count_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (!issue_done_q) begin
						rd_v_s1 <= 1'b1;
						if (addr_q == LAST_ADDR) begin
							issue_done_q <= 1'b1;
						end else begin
							addr_q <= addr_q + AW'(1);
						end
					end else begin
						rd_v_s1 <= 1'b0;
					end
					if (hit) begin
						found_q <= 1'b1;
						if (req_q.action == ptt_pkg::ACT_ADD) begin
							last_id_q <= next_id;
							issued_q <= next_id;
						end
					end
					if (expire && count_q != ptt_pkg::COUNT_MAX) begin
						count_q <= count_q + ptt_pkg::COUNT_W'(1);
					end
					if (issue_done_q && !rd_v_s1) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the pipeline.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (rd_en) begin
			addr_s1 <= addr_q;
		end
	end

	// Result of the finished sweep.
	always_comb begin
		result.issued_id = '0;
		result.status = ptt_pkg::STS_OK;
		result.expired_count = '0;
		case (req_q.action)
			ptt_pkg::ACT_ADD: begin
				result.issued_id = issued_q;
				result.status = found_q ? ptt_pkg::STS_OK : ptt_pkg::STS_FULL;
			end
			ptt_pkg::ACT_RESPONSE: begin
				result.status = found_q ? ptt_pkg::STS_OK : ptt_pkg::STS_NOT_FOUND;
			end
			ptt_pkg::ACT_TICK: begin
				result.expired_count = count_q;
			end
			default: begin
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign res_load = (state_q == S_RESULT) && res_free;

endmodule

`default_nettype wire

### hw/rtl/pending_command_timeout_table.sv
// Each item runs from its transfer on req to its result entering the output register as
// follows: the sweep engine walks every table entry once through the single entry
// memory, one entry per cycle, with registered read data, then closes the sweep in S_SWEEP
// and loads the result from S_RESULT once the output register is free. The next item is taken
// only once the engine is back in S_IDLE, after the last result has been loaded. An add
// takes the lowest free slot and issues the next id (wrapping to 1), a response frees the
// lowest valid entry with the given id, and a tick ages all valid entries and counts those
// that expire. After reset the block runs a clearing pass over the memory and takes no
// item until it ends; timeout_ticks writes on cfg are taken at any time.
//
// Top level of the pending command timeout table: configuration register and output register.
// Depends on ptt_pkg and ptt_sweep.
`default_nettype none

module pending_command_timeout_table #(
	parameter int TABLE_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire ptt_pkg::req_t req,
	output logic res_valid,
	input wire logic res_ready,
	output ptt_pkg::res_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [ptt_pkg::LIFE_W-1:0] cfg_data
);

	logic [ptt_pkg::LIFE_W-1:0] timeout_q;
	logic res_valid_q;
	ptt_pkg::res_t res_q;
	logic eng_idle;
	logic res_load;
	logic res_free;
	ptt_pkg::res_t eng_result;

	// Lifetime register, written by a cfg transfer.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= ptt_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			timeout_q <= cfg_data;
		end
	end

	assign req_ready = eng_idle;
	assign res_free = !res_valid_q || res_ready;

	ptt_sweep #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.start(req_valid),
		.req(req),
		.timeout_ticks(timeout_q),
		.res_free(res_free),
		.idle(eng_idle),
		.res_load(res_load),
		.result(eng_result)
	);

	// Output register; the engine may start the next item while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= eng_result;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

`default_nettype wire
